>>> design/gha_pkg.sv
// Shared types, sizes and helper functions for the generational handle allocator.
// Depends on nothing; gha_ctrl, the top level and gha_checker import it.
package gha_pkg;

  localparam int unsigned SLOT_COUNT = 4096;
  localparam int unsigned GEN_WIDTH  = 16;

  localparam int unsigned IDX_W   = $clog2(SLOT_COUNT);
  localparam int unsigned CNT_W   = $clog2(SLOT_COUNT + 1);
  localparam int unsigned FIELD_W = 16;
  localparam int unsigned CMP_W   = (CNT_W > FIELD_W) ? CNT_W : FIELD_W;

  typedef logic [GEN_WIDTH-1:0] gen_t;
  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [CNT_W-1:0]     cnt_t;

  typedef enum logic [1:0] {
    REQ_CREATE   = 2'd0,
    REQ_DESTROY  = 2'd1,
    REQ_LOOKUP   = 2'd2,
    REQ_VALIDATE = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_EXHAUSTED = 2'd1,
    STATUS_INVALID   = 2'd2
  } status_e;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  typedef struct packed {
    req_e               req_type;
    logic [FIELD_W-1:0] slot_index;
    logic [FIELD_W-1:0] handle_generation;
  } req_t;

  typedef struct packed {
    status_e            status;
    logic [FIELD_W-1:0] result_index;
    logic [FIELD_W-1:0] result_generation;
    logic               handle_ok;
  } rsp_t;

  // One slot table entry
  typedef struct packed {
    logic alive;
    gen_t gen;
  } slot_word_t;

  // Free stack entry: slot plus the generation it got when freed
  typedef struct packed {
    idx_t slot;
    gen_t gen;
  } stack_word_t;

  typedef struct packed {
    logic       re;
    idx_t       raddr;
    logic       we;
    idx_t       waddr;
    slot_word_t wdata;
  } slot_mem_req_t;

  typedef struct packed {
    logic        re;
    idx_t        raddr;
    logic        we;
    idx_t        waddr;
    stack_word_t wdata;
  } stack_mem_req_t;

  // Low FIELD_W bits of a generation, zero-extended when narrower
  function automatic logic [FIELD_W-1:0] gen_to_field(gen_t g);
    logic [GEN_WIDTH+FIELD_W-1:0] ext;
    ext = {{FIELD_W{1'b0}}, g};
    return ext[FIELD_W-1:0];
  endfunction

  // Full-width compare of stored generation against a handle's generation
  function automatic logic gen_match(gen_t g, logic [FIELD_W-1:0] h);
    return {{FIELD_W{1'b0}}, g} == {{GEN_WIDTH{1'b0}}, h};
  endfunction

endpackage

>>> design/gha_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies.
module gha_ram #(
  parameter int unsigned DEPTH = 2,
  parameter int unsigned WIDTH = 1
) (
  input  logic                     clk_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/gha_ctrl.sv
// Request sequencer: issues memory reads, does the read-modify-write of slot table
// and free stack, keeps the counters and the output register. Uses gha_pkg.
module gha_ctrl (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  gha_pkg::req_t           in_data_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output gha_pkg::rsp_t           out_data_o,
  output gha_pkg::slot_mem_req_t  slot_req_o,
  input  gha_pkg::slot_word_t     slot_rd_i,
  output gha_pkg::stack_mem_req_t stack_req_o,
  input  gha_pkg::stack_word_t    stack_rd_i
);
  import gha_pkg::*;

  state_e state_q, state_d;
  req_t   req_q;
  logic   out_valid_q, out_valid_d;
  rsp_t   out_data_q, rsp;
  cnt_t   free_depth_q, free_depth_d;
  cnt_t   next_fresh_q, next_fresh_d;
  cnt_t   depth_m1;
  logic   in_accept, fire, in_range, alive, fresh_avail;
  gen_t   gen_inc;

  assign in_accept = in_valid_i && (state_q == ST_IDLE);
  assign in_stall_o = (state_q != ST_IDLE);
  assign depth_m1 = free_depth_q - cnt_t'(1);

  // Entries at or above the high-water mark were never written: read as dead
  assign in_range    = CMP_W'(req_q.slot_index) < CMP_W'(next_fresh_q);
  assign alive       = in_range && slot_rd_i.alive;
  assign fresh_avail = next_fresh_q < cnt_t'(SLOT_COUNT);
  assign gen_inc     = slot_rd_i.gen + gen_t'(1);
  assign fire        = (state_q == ST_EXEC) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d      = state_q;
    free_depth_d = free_depth_q;
    next_fresh_d = next_fresh_q;

    rsp.status            = STATUS_OK;
    rsp.result_index      = req_q.slot_index;
    rsp.result_generation = '0;
    rsp.handle_ok         = 1'b0;

    // Reads are launched on the accept edge; data is ready in ST_EXEC
    slot_req_o.re     = in_accept;
    slot_req_o.raddr  = in_data_i.slot_index[IDX_W-1:0];
    stack_req_o.re    = in_accept;
    stack_req_o.raddr = depth_m1[IDX_W-1:0];

    slot_req_o.we    = 1'b0;
    slot_req_o.waddr = req_q.slot_index[IDX_W-1:0];
    slot_req_o.wdata = '{alive: 1'b0, gen: gen_inc};

    stack_req_o.we    = 1'b0;
    stack_req_o.waddr = free_depth_q[IDX_W-1:0];
    stack_req_o.wdata = '{slot: req_q.slot_index[IDX_W-1:0], gen: gen_inc};

    case (req_q.req_type)
      REQ_CREATE: begin
        if (free_depth_q != '0) begin
          // pop: generation travels with the stacked slot
          rsp.result_index      = FIELD_W'(stack_rd_i.slot);
          rsp.result_generation = gen_to_field(stack_rd_i.gen);
          slot_req_o.we         = fire;
          slot_req_o.waddr      = stack_rd_i.slot;
          slot_req_o.wdata      = '{alive: 1'b1, gen: stack_rd_i.gen};
          if (fire) begin
            free_depth_d = depth_m1;
          end
        end else if (fresh_avail) begin
          rsp.result_index = FIELD_W'(next_fresh_q);
          slot_req_o.we    = fire;
          slot_req_o.waddr = next_fresh_q[IDX_W-1:0];
          slot_req_o.wdata = '{alive: 1'b1, gen: '0};
          if (fire) begin
            next_fresh_d = next_fresh_q + cnt_t'(1);
          end
        end else begin
          rsp.status       = STATUS_EXHAUSTED;
          rsp.result_index = '0;
        end
      end
      REQ_DESTROY: begin
        if (!alive) begin
          rsp.status = STATUS_INVALID;
        end else begin
          slot_req_o.we = fire;
          if (free_depth_q < cnt_t'(SLOT_COUNT)) begin
            stack_req_o.we = fire;
            if (fire) begin
              free_depth_d = free_depth_q + cnt_t'(1);
            end
          end
        end
      end
      REQ_LOOKUP, REQ_VALIDATE: begin
        if (!alive) begin
          rsp.status = STATUS_INVALID;
        end else begin
          rsp.result_generation = gen_to_field(slot_rd_i.gen);
          rsp.handle_ok = (req_q.req_type == REQ_VALIDATE) &&
                          gen_match(slot_rd_i.gen, req_q.handle_generation);
        end
      end
      default: begin
      end
    endcase

    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (fire) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (fire) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      out_valid_q  <= 1'b0;
      free_depth_q <= '0;
      next_fresh_q <= '0;
    end else begin
      state_q      <= state_d;
      out_valid_q  <= out_valid_d;
      free_depth_q <= free_depth_d;
      next_fresh_q <= next_fresh_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      req_q <= in_data_i;
    end
    if (fire) begin
      out_data_q <= rsp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

>>> design/generational_handle_allocator.sv
// Top level of the generational handle allocator: sequencer plus slot table and
// free stack RAMs. Uses gha_pkg, gha_ctrl and gha_ram.
//
// Usage:
//   Request channel (in_valid_i / in_stall_o / in_data_i): create, destroy,
//   lookup or validate. A transfer happens on a clock edge with valid high and
//   stall low. Response channel (out_valid_o / out_stall_i / out_data_o): one
//   response per request, in request order.
// Request sequence:
//   A request first reads the slot table and the free stack top (synchronous
//   RAMs, registered read data), then in ST_EXEC modifies and writes back and
//   loads the response into the output register. A new request is taken only
//   in ST_IDLE, once the previous one has written back.
// Stall:
//   While the response waits on out_stall_i, the next request is still taken
//   and read; its write-back and response wait until the output register frees.
// Reset:
//   rst_ni clears the counters and the handshake state. The slot
//   table needs no clearing pass: entries at or above the high-water counter
//   read as dead with generation zero, and only those below it are ever written.
module generational_handle_allocator (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  gha_pkg::req_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output gha_pkg::rsp_t out_data_o
);
  import gha_pkg::*;

  slot_mem_req_t  slot_req;
  stack_mem_req_t stack_req;
  logic [$bits(slot_word_t)-1:0]  slot_rdata;
  logic [$bits(stack_word_t)-1:0] stack_rdata;
  slot_word_t  slot_rd;
  stack_word_t stack_rd;

  assign slot_rd  = slot_rdata;
  assign stack_rd = stack_rdata;

  gha_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .slot_req_o  (slot_req),
    .slot_rd_i   (slot_rd),
    .stack_req_o (stack_req),
    .stack_rd_i  (stack_rd)
  );

  // Alive bit and generation per slot
  gha_ram #(
    .DEPTH (SLOT_COUNT),
    .WIDTH ($bits(slot_word_t))
  ) u_slot_ram (
    .clk_i   (clk_i),
    .re_i    (slot_req.re),
    .raddr_i (slot_req.raddr),
    .we_i    (slot_req.we),
    .waddr_i (slot_req.waddr),
    .wdata_i (slot_req.wdata),
    .rdata_o (slot_rdata)
  );

  // LIFO of freed slots, each with its post-destroy generation
  gha_ram #(
    .DEPTH (SLOT_COUNT),
    .WIDTH ($bits(stack_word_t))
  ) u_stack_ram (
    .clk_i   (clk_i),
    .re_i    (stack_req.re),
    .raddr_i (stack_req.raddr),
    .we_i    (stack_req.we),
    .waddr_i (stack_req.waddr),
    .wdata_i (stack_req.wdata),
    .rdata_o (stack_rdata)
  );

endmodule

>>> design/gha_checker.sv
// Port-level checks for the generational handle allocator, bound to the top level.
// Uses gha_pkg.
module gha_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_stall_o,
  input gha_pkg::req_t in_data_i,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input gha_pkg::rsp_t out_data_o
);
  import gha_pkg::*;

  // a request transfer always occupies the sequencer for the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("request taken while previous one still executing");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("stalled response changed");

  a_exhausted_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status == STATUS_EXHAUSTED) |->
      (out_data_o.result_index == '0 && out_data_o.result_generation == '0))
    else $error("exhausted response carries nonzero index or generation");

  a_fail_no_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status != STATUS_OK) |->
      (!out_data_o.handle_ok && out_data_o.result_generation == '0))
    else $error("failed request reports a handle match or generation");

endmodule

bind generational_handle_allocator gha_checker u_gha_checker (.*);
